@@ sv/sp2c_pkg.sv @@
// Shared types, constants and table builder for the scan polar-to-Cartesian block.
// Depends on nothing; sp2c_trig_rom and scan_polar_to_cartesian use it.
package sp2c_pkg;

	localparam int BEAMS   = 361;
	localparam int BEAM_W  = $clog2(BEAMS);
	localparam int RANGE_W = 16;
	localparam int SLOT_W  = 9;
	localparam int COORD_W = 17;
	localparam int TRIG_W  = 16;

	localparam logic [RANGE_W-1:0] LIMIT_RESET = RANGE_W'(3000);

	// Angle step of 1.57/180 rad and pi/2, both in Q32 radians
	localparam logic [63:0] ANGLE_STEP_Q32 = 64'd37461659;
	localparam logic [63:0] HALF_PI_Q32    = 64'd6746518852;
	localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

	// Sine and cosine of one beam, Q1.15
	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	typedef trig_t [BEAMS-1:0] trig_tab_t;

	// Q30 to Q1.15, half away from zero, saturated
	function automatic logic signed [TRIG_W-1:0] q30_to_q15(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r   = (mag + (64'd1 << 14)) >> 15;
		if (v[63]) begin
			if (r > 64'd32768) r = 64'd32768;
			return TRIG_W'(-r);
		end
		if (r > 64'd32767) r = 64'd32767;
		return TRIG_W'(r);
	endfunction

	// Truncating Taylor series on the in-quadrant remainder, then quadrant map
	function automatic trig_t beam_trig(input int unsigned b);
		logic [63:0] theta;
		logic [63:0] q;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic signed [63:0] s;
		logic signed [63:0] c;
		trig_t t;
		theta = 64'(b) * ANGLE_STEP_Q32;
		q     = theta / HALF_PI_Q32;
		x     = (theta - q * HALF_PI_Q32) >> 2;
		x2    = (x * x) >> 30;
		ts    = x;
		tc    = ONE_Q30;
		s     = $signed(x);
		c     = $signed(ONE_Q30);
		for (int k = 1; k <= 7; k++) begin
			ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				s = s - $signed(ts);
				c = c - $signed(tc);
			end else begin
				s = s + $signed(ts);
				c = c + $signed(tc);
			end
		end
		case (q[1:0])
			2'd0: begin
				t.sin_v = q30_to_q15(s);
				t.cos_v = q30_to_q15(c);
			end
			2'd1: begin
				t.sin_v = q30_to_q15(c);
				t.cos_v = q30_to_q15(-s);
			end
			2'd2: begin
				t.sin_v = q30_to_q15(-s);
				t.cos_v = q30_to_q15(-c);
			end
			default: begin
				t.sin_v = q30_to_q15(-c);
				t.cos_v = q30_to_q15(s);
			end
		endcase
		return t;
	endfunction

	// Full table, worked out at elaboration
	function automatic trig_tab_t build_trig_tab();
		trig_tab_t tab;
		for (int i = 0; i < BEAMS; i++) begin
			tab[i] = beam_trig(i);
		end
		return tab;
	endfunction

endpackage

@@ sv/sp2c_trig_rom.sv @@
// Beam sine/cosine ROM with registered read port.
// Depends on sp2c_pkg for the table builder and trig_t.
module sp2c_trig_rom (
	input  logic                       clk,
	input  logic                       en,
	input  logic [sp2c_pkg::BEAM_W-1:0] addr,
	output sp2c_pkg::trig_t            data
);

	localparam sp2c_pkg::trig_tab_t TAB = sp2c_pkg::build_trig_tab();

	// Read on enable, hold otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			data <= TAB[addr];
		end
	end

endmodule

@@ sv/scan_polar_to_cartesian.sv @@
// Top level: laser scan polar-to-Cartesian conversion with compacted slots.
// Depends on sp2c_pkg and sp2c_trig_rom.
//
//  channel  direction  handshake                      payload
//  sample   in         sample_valid / sample_stall    range_mm, first_of_scan
//  result   out        result_valid / result_stall    point_valid, x_mm, y_mm, slot, scan_end
//  config   in         cfg_write                      cfg_data (range_limit_mm)
//
// One transaction per cycle sustained while result_stall is low; a sample goes
// through stage 1 and then stage 2. Stage 1 registers the table read and the
// counters' view, stage 2 is the result register after the two 16x16 products.
// arst_n clears the counters, the stage valids and sets the limit to 3000.
// sample_stall rises only while both stages hold a transaction and result_stall is high.
module scan_polar_to_cartesian (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [sp2c_pkg::RANGE_W-1:0]       range_mm,
	input  logic                               first_of_scan,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               point_valid,
	output logic signed [sp2c_pkg::COORD_W-1:0] x_mm,
	output logic signed [sp2c_pkg::COORD_W-1:0] y_mm,
	output logic [sp2c_pkg::SLOT_W-1:0]        slot,
	output logic                               scan_end,
	input  logic                               cfg_write,
	input  logic [sp2c_pkg::RANGE_W-1:0]       cfg_data
);

	localparam int BW = sp2c_pkg::BEAM_W;
	localparam int SW = sp2c_pkg::SLOT_W;
	localparam int RW = sp2c_pkg::RANGE_W;
	localparam int CW = sp2c_pkg::COORD_W;
	localparam int TW = sp2c_pkg::TRIG_W;
	localparam int PW = RW + TW;

	logic [RW-1:0] limit_q;
	logic [BW-1:0] beam_q;
	logic [SW-1:0] slot_q;

	logic          v_s1;
	logic          pv_s1;
	logic          last_s1;
	logic [RW-1:0] range_s1;
	logic [SW-1:0] slot_s1;
	sp2c_pkg::trig_t trig_s1;

	logic          en1;
	logic          en2;
	logic          acc;
	logic [BW-1:0] beam_cur;
	logic [SW-1:0] slot_cur;
	logic          pv_cur;
	logic          last_cur;

	logic [TW-1:0] sin_mag;
	logic [TW-1:0] cos_mag;
	logic [PW-1:0] sin_prod;
	logic [PW-1:0] cos_prod;
	logic signed [CW-1:0] sin_p;
	logic signed [CW-1:0] cos_p;

	// Stage enables: a stage advances when it is empty or its successor moves
	assign en2          = !result_valid || !result_stall;
	assign en1          = !v_s1 || en2;
	assign sample_stall = !en1;
	assign acc          = sample_valid && en1;

	// Current beam and slot, restarted by first_of_scan
	assign beam_cur = first_of_scan ? '0 : beam_q;
	assign slot_cur = first_of_scan ? '0 : slot_q;
	assign pv_cur   = range_mm < limit_q;
	assign last_cur = beam_cur == BW'(sp2c_pkg::BEAMS - 1);

	// Hold the range limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sp2c_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

	// Advance beam and slot counters per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (last_cur) begin
				beam_q <= '0;
				slot_q <= '0;
			end else begin
				beam_q <= beam_cur + BW'(1);
				slot_q <= pv_cur ? slot_cur + SW'(1) : slot_cur;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= sample_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pv_s1    <= pv_cur;
			last_s1  <= last_cur;
			range_s1 <= range_mm;
			slot_s1  <= pv_cur ? slot_cur : '0;
		end
	end

	sp2c_trig_rom u_rom (
		.clk  (clk),
		.en   (acc),
		.addr (beam_cur),
		.data (trig_s1)
	);

	// Scale by sine and cosine, round half away from zero
	assign sin_mag  = trig_s1.sin_v[TW-1] ? TW'(-trig_s1.sin_v) : TW'(trig_s1.sin_v);
	assign cos_mag  = trig_s1.cos_v[TW-1] ? TW'(-trig_s1.cos_v) : TW'(trig_s1.cos_v);
	assign sin_prod = PW'(range_s1) * PW'(sin_mag);
	assign cos_prod = PW'(range_s1) * PW'(cos_mag);
	assign sin_p    = $signed(CW'((sin_prod + PW'(16384)) >> 15));
	assign cos_p    = $signed(CW'((cos_prod + PW'(16384)) >> 15));

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en2) begin
			result_valid <= v_s1;
		end
	end

	// Stage 2 payload: drop coordinates of rejected samples
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			point_valid <= pv_s1;
			scan_end    <= last_s1;
			slot        <= slot_s1;
			if (pv_s1) begin
				x_mm <= trig_s1.sin_v[TW-1] ? -sin_p : sin_p;
				y_mm <= trig_s1.cos_v[TW-1] ? cos_p : -cos_p;
			end else begin
				x_mm <= '0;
				y_mm <= '0;
			end
		end
	end

	// Last beam of a scan sends both counters back to zero
	a_scan_wrap : assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_cur) |=> (beam_q == '0 && slot_q == '0))
		else $error("counters not cleared after last beam");

	// Beam counter stays inside the scan
	a_beam_range : assert property (@(posedge clk) disable iff (!arst_n)
		beam_q <= BW'(sp2c_pkg::BEAMS - 1))
		else $error("beam counter beyond scan");

	// Rejected point carries zero coordinates and slot
	a_reject_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !point_valid) |-> (x_mm == '0 && y_mm == '0 && slot == '0))
		else $error("rejected point with nonzero fields");

	// Input stalls only when both stages are full and the output is held
	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (v_s1 && result_valid && result_stall))
		else $error("input stalled with room in the pipeline");

	// A stage 1 transaction moves to the result register when it is free
	a_advance : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en2) |=> result_valid)
		else $error("transaction lost between stages");

endmodule
